// ===== sv/glmtd_pkg.sv =====
`timescale 1ns / 1ps

package glmtd_pkg;

  // Grid limits: cells whose row or column lies at or above these are ignored.
  localparam int unsigned MaxRows   = 256;
  localparam int unsigned MaxCols   = 256;

  // Histogram store: one entry per row or per column index.
  localparam int unsigned IdxW      = 8;
  localparam int unsigned AxisDepth = 1 << IdxW;
  localparam int unsigned HistW     = 9;
  localparam logic [HistW-1:0] HistMax = '1;

  // Totals and results.
  localparam int unsigned TotW      = 17;
  localparam int unsigned OnesW     = 17;
  localparam logic [OnesW-1:0] OnesMax = '1;
  localparam int unsigned DistW     = 25;
  localparam logic [DistW-1:0] DistMax = '1;

  // Queue between the front and the back.
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAw       = 2;

  typedef struct packed {
    logic            cell_req;
    logic [7:0]      row;
    logic [7:0]      col;
    logic            last;
  } cell_in_t;

  typedef struct packed {
    logic [DistW-1:0] total_distance;
    logic [OnesW-1:0] occupied;
  } result_t;

  // Classified word held in the queue.
  typedef struct packed {
    logic            occ;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            last;
  } q_entry_t;

  // Control from the back controller to one axis unit.
  typedef struct packed {
    logic            upd;
    logic [IdxW-1:0] idx;
    logic            scan_start;
  } axis_req_t;

  // Status from one axis unit back to the controller.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DistW-1:0] cost;
  } axis_rsp_t;

endpackage

// ===== sv/glmtd_front.sv =====
`timescale 1ns / 1ps

module glmtd_front import glmtd_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cell_in_t in_data_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output q_entry_t push_data_o
);

  logic occ;

  // A cell counts only when it is occupied and lies inside the grid limits.
  assign occ = in_data_i.cell_req &&
               (32'(in_data_i.row) < MaxRows) &&
               (32'(in_data_i.col) < MaxCols);

  // Words that neither count nor close a grid have no effect and are dropped here.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (occ || in_data_i.last);

  assign push_data_o.occ  = occ;
  assign push_data_o.row  = in_data_i.row;
  assign push_data_o.col  = in_data_i.col;
  assign push_data_o.last = in_data_i.last;

endmodule

// ===== sv/glmtd_queue.sv =====
`timescale 1ns / 1ps

module glmtd_queue import glmtd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  q_entry_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output q_entry_t pop_data_o
);

  q_entry_t             slot_q [QDepth];
  logic [QAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QAw:0]         cnt_q;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != (QAw+1)'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== sv/glmtd_axis.sv =====
`timescale 1ns / 1ps

module glmtd_axis import glmtd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  axis_req_t req_i,
  output axis_rsp_t rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;

  logic [2:0]           state_q;

  // Histogram store with one valid bit per entry; an unwritten entry reads as zero.
  logic [HistW-1:0]     mem_q [AxisDepth];
  logic [AxisDepth-1:0] vld_q;
  logic [HistW-1:0]     rd_q;
  logic                 rd_vld_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_wa, mem_ra;
  logic [HistW-1:0]     mem_wd;
  logic [HistW-1:0]     h;

  // Update pipeline and last-write bypass.
  logic                 s1_valid_q, lw_valid_q;
  logic [IdxW-1:0]      s1_idx_q, lw_idx_q;
  logic [HistW-1:0]     lw_data_q, cur;
  logic                 upd_we;
  logic [TotW-1:0]      tot_q;

  // Scan datapath.
  logic                 scanning;
  logic [IdxW-1:0]      scan_idx_q, sc_idx_q;
  logic                 sc_vld_q;
  logic [TotW-1:0]      cnt_q, cb_q, seen;
  logic [DistW-1:0]     wrun_q, wb_q, pl_q, pr_q, cost_q;
  logic [IdxW-1:0]      med_q;
  logic                 found_q, done_q;

  assign scanning = (state_q == S_SCAN);
  assign h        = rd_vld_q ? rd_q : '0;
  assign cur      = (lw_valid_q && (lw_idx_q == s1_idx_q)) ? lw_data_q : h;
  assign upd_we   = s1_valid_q && (cur != HistMax);
  assign seen     = cnt_q + TotW'(h);

  // The scan reads and clears one entry a cycle; otherwise the update stage writes.
  assign mem_ra = scanning ? scan_idx_q : req_i.idx;
  assign mem_we = scanning || upd_we;
  assign mem_wa = scanning ? scan_idx_q : s1_idx_q;
  assign mem_wd = scanning ? '0 : cur + 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[mem_wa] <= 1'b1;
      rd_vld_q <= vld_q[mem_ra];
    end
  end

  // Control: update stage, count total and the scan sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
      sc_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      tot_q      <= '0;
      scan_idx_q <= '0;
    end else begin
      s1_valid_q <= req_i.upd;
      lw_valid_q <= upd_we;
      sc_vld_q   <= scanning;
      done_q     <= (state_q == S_SUM);
      if (upd_we) tot_q <= tot_q + 1'b1;
      if (sc_vld_q && !found_q && (seen > (tot_q >> 1))) found_q <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (req_i.scan_start) begin
            state_q    <= S_SCAN;
            scan_idx_q <= '0;
            found_q    <= 1'b0;
          end
        end
        S_SCAN: begin
          scan_idx_q <= scan_idx_q + 1'b1;
          if (scan_idx_q == IdxW'(AxisDepth - 1)) state_q <= S_TAIL;
        end
        S_TAIL: state_q <= S_MUL;
        S_MUL:  state_q <= S_SUM;
        S_SUM: begin
          state_q <= S_IDLE;
          tot_q   <= '0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload: running count and weighted sum, median capture, final cost.
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= req_i.idx;
    lw_idx_q  <= s1_idx_q;
    lw_data_q <= cur + 1'b1;
    sc_idx_q  <= scan_idx_q;
    if (state_q == S_IDLE && req_i.scan_start) begin
      cnt_q  <= '0;
      wrun_q <= '0;
      med_q  <= '0;
      cb_q   <= '0;
      wb_q   <= '0;
    end else if (sc_vld_q) begin
      cnt_q  <= seen;
      wrun_q <= wrun_q + DistW'(sc_idx_q) * DistW'(h);
      if (!found_q && (seen > (tot_q >> 1))) begin
        med_q <= sc_idx_q;
        cb_q  <= cnt_q;
        wb_q  <= wrun_q;
      end
    end
    // Cost below the median is med*count - weight; above it weight - med*count.
    if (state_q == S_MUL) begin
      pl_q <= DistW'(med_q) * DistW'(cb_q);
      pr_q <= DistW'(med_q) * DistW'(tot_q - cb_q);
    end
    if (state_q == S_SUM) begin
      cost_q <= (pl_q - wb_q) + (wrun_q - wb_q) - pr_q;
    end
  end

  assign rsp_o.busy = s1_valid_q;
  assign rsp_o.done = done_q;
  assign rsp_o.cost = cost_q;

  // Updates arrive only while no scan is running.
  a_upd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.upd |-> state_q == S_IDLE)
    else $error("histogram update during scan");

  // A scan starts only once the update stage has written back.
  a_start_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.scan_start |-> (!s1_valid_q && state_q == S_IDLE))
    else $error("scan started with update in flight");

  // The count total is cleared together with the finished result.
  a_tot_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> tot_q == '0)
    else $error("count total not cleared after scan");

endmodule

// ===== sv/glmtd_back.sv =====
`timescale 1ns / 1ps

module glmtd_back import glmtd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  q_entry_t  q_data_i,
  output axis_req_t row_req_o,
  output axis_req_t col_req_o,
  input  axis_rsp_t row_rsp_i,
  input  axis_rsp_t col_rsp_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   out_data_o
);

  localparam logic [1:0] B_RUN   = 2'd0;
  localparam logic [1:0] B_DRAIN = 2'd1;
  localparam logic [1:0] B_WAIT  = 2'd2;
  localparam logic [1:0] B_OUT   = 2'd3;

  logic [1:0]       state_q;
  logic [OnesW-1:0] ones_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             pop, start, load;
  logic [DistW:0]   dsum;

  assign q_ready_o = (state_q == B_RUN);
  assign pop       = q_valid_i && q_ready_o;
  assign start     = (state_q == B_DRAIN) && !row_rsp_i.busy && !col_rsp_i.busy;
  assign load      = (state_q == B_OUT) && (!out_valid_q || out_ready_i);

  // Each counted cell goes to both axis units.
  assign row_req_o.upd        = pop && q_data_i.occ;
  assign row_req_o.idx        = q_data_i.row;
  assign row_req_o.scan_start = start;
  assign col_req_o.upd        = pop && q_data_i.occ;
  assign col_req_o.idx        = q_data_i.col;
  assign col_req_o.scan_start = start;

  // Combined cost, saturated to the result width.
  assign dsum = {1'b0, row_rsp_i.cost} + {1'b0, col_rsp_i.cost};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_RUN;
      ones_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && q_data_i.occ && ones_q != OnesMax) ones_q <= ones_q + 1'b1;
      if (load)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        B_RUN:   if (pop && q_data_i.last) state_q <= B_DRAIN;
        B_DRAIN: if (start) state_q <= B_WAIT;
        B_WAIT:  if (row_rsp_i.done) state_q <= B_OUT;
        B_OUT: begin
          if (load) begin
            state_q <= B_RUN;
            ones_q  <= '0;
          end
        end
        default: state_q <= B_RUN;
      endcase
    end
  end

  // Output register parts the result from the downstream side.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.total_distance <= dsum[DistW] ? DistMax : dsum[DistW-1:0];
      out_q.occupied       <= ones_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Both axis units run in lock step.
  a_axes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_rsp_i.done == col_rsp_i.done)
    else $error("row and column scans finished apart");

endmodule

// ===== sv/grid_l1_median_total_distance.sv =====
`timescale 1ns / 1ps

// Best meeting point on a binary grid. Cells stream in one word a clock while the queue has
// room, each with its row and column; occupied cells are counted into per-row and per-column
// histograms held in 256-entry memories, updated by a two-stage read-modify-write with
// bypass. Unoccupied cells that do not close a grid are dropped at the front. After the word
// marked last, each axis histogram is swept once, one entry a cycle, to find the median and
// the weighted sums, and cleared in the same sweep; the result (sum of Manhattan distances
// to the median point, and the occupied count) is offered after the sweep and the multiply
// and sum steps, once the output register is free. During that sweep a four-word queue
// keeps accepting the next grid's words, after which input stalls. Histogram memories read
// as zero after reset through per-entry valid bits, so no clearing pass is needed.
module grid_l1_median_total_distance import glmtd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cell_in_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_data_o
);

  logic      push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t  push_data, pop_data;
  axis_req_t row_req, col_req;
  axis_rsp_t row_rsp, col_rsp;

  // Front: accept and classify cells.
  glmtd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue between front and back.
  glmtd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: counting, scan control and the result register.
  glmtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .row_req_o   (row_req),
    .col_req_o   (col_req),
    .row_rsp_i   (row_rsp),
    .col_rsp_i   (col_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Row and column histogram units.
  glmtd_axis u_row_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (row_req),
    .rsp_o  (row_rsp)
  );

  glmtd_axis u_col_axis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (col_req),
    .rsp_o  (col_rsp)
  );

endmodule

// ===== test/grid_l1_median_total_distance_tb.sv =====
`timescale 1ns / 1ps

module grid_l1_median_total_distance_tb;
  import glmtd_pkg::*;

  // Receiver hold-off length and the longest quiet stretch tolerated.
  localparam int HoldCycles = 1500;
  localparam int QuietLimit = 20000;
  // Repeats of one cell, enough to push its row and column counts past their ceiling.
  localparam int SatRepeats = 520;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  cell_in_t in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  result_t  out_data_o;

  // Idle and stall probabilities in percent, changed only at rising edges.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // A toggle of hold_tgl asks the receiver for one long hold-off.
  bit hold_tgl  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int errors = 0;

  // Histograms of the predicted grid and the results still owed.
  logic [HistW-1:0] row_hist [AxisDepth];
  logic [HistW-1:0] col_hist [AxisDepth];
  logic [OnesW-1:0] ones_count;
  result_t          owed_results [$];

  grid_l1_median_total_distance u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Weighted distance of one axis histogram to its median index.
  function automatic longint unsigned axis_spread(input bit use_cols);
    longint unsigned  total;
    longint unsigned  seen;
    longint unsigned  cost;
    longint unsigned  d;
    int unsigned      len;
    int unsigned      med;
    bit               found;
    logic [HistW-1:0] h;
    total = 0;
    seen  = 0;
    cost  = 0;
    med   = 0;
    found = 1'b0;
    len   = use_cols ? MaxCols : MaxRows;
    for (int unsigned i = 0; i < len; i++) begin
      h = use_cols ? col_hist[i] : row_hist[i];
      total += h;
    end
    if (total == 0) return 0;
    for (int unsigned i = 0; i < len; i++) begin
      h = use_cols ? col_hist[i] : row_hist[i];
      seen += h;
      if (!found && seen > total / 2) begin
        med   = i;
        found = 1'b1;
      end
    end
    for (int unsigned i = 0; i < len; i++) begin
      h = use_cols ? col_hist[i] : row_hist[i];
      d = (i >= med) ? longint'(i - med) : longint'(med - i);
      cost += d * h;
    end
    return cost;
  endfunction

  // Clear the predicted grid.
  task automatic clear_grid();
    for (int i = 0; i < AxisDepth; i++) begin
      row_hist[i] = '0;
      col_hist[i] = '0;
    end
    ones_count = '0;
  endtask

  // Count one accepted word and, on the last word, predict the result.
  task automatic count_cell(input cell_in_t w);
    longint unsigned sum;
    result_t         res;
    if (w.cell_req && w.row < MaxRows && w.col < MaxCols) begin
      if (row_hist[w.row] != HistMax) row_hist[w.row]++;
      if (col_hist[w.col] != HistMax) col_hist[w.col]++;
      if (ones_count != OnesMax) ones_count++;
    end
    if (w.last) begin
      sum = axis_spread(1'b0) + axis_spread(1'b1);
      if (sum > DistMax) sum = DistMax;
      res.total_distance = sum[DistW-1:0];
      res.occupied       = ones_count;
      owed_results = {owed_results, res};
      clear_grid();
    end
  endtask

  // Offer one word after a random gap, wait for it to be taken, then predict.
  task automatic send_word(input cell_in_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    count_cell(w);
  endtask

  function automatic cell_in_t make_cell(input logic occ, input int r, input int c,
                                         input logic fin);
    cell_in_t w;
    w.cell_req = occ;
    w.row      = 8'(r);
    w.col      = 8'(c);
    w.last     = fin;
    return w;
  endfunction

  function automatic int pick_span();
    case ($urandom_range(3))
      0:       return 1;
      1:       return 4;
      2:       return 32;
      default: return 256;
    endcase
  endfunction

  // One grid of random shape: clustered or spread, dense or sparse. Counts every word sent.
  task automatic send_random_grid(input int n_cells, inout int counted);
    cell_in_t w;
    int       density;
    int       r_span;
    int       c_span;
    int       r_base;
    int       c_base;
    case ($urandom_range(2))
      0:       density = 100;
      1:       density = 60;
      default: density = 20;
    endcase
    r_span = pick_span();
    c_span = pick_span();
    r_base = $urandom_range(255);
    c_base = $urandom_range(255);
    for (int i = 0; i < n_cells; i++) begin
      w = make_cell($urandom_range(99) < density,
                    r_base + $urandom_range(r_span - 1),
                    c_base + $urandom_range(c_span - 1), i == n_cells - 1);
      if (w.last) w.cell_req = 1'($urandom_range(1));
      send_word(w);
      counted++;
    end
  endtask

  function automatic int pick_grid_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(16, 1);
    if (k < 95) return $urandom_range(80, 17);
    return $urandom_range(300, 81);
  endfunction

  // Park the input, then change the pace at a rising edge.
  task automatic set_pace(input int idle_pct, input int stall);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
  endtask

  // Empty grid, corners, even and odd counts, repeats, last occupied or not.
  task automatic test_directed_corners();
    set_pace(0, 0);
    send_word(make_cell(1'b0, 0, 0, 1'b1));
    send_word(make_cell(1'b1, 255, 255, 1'b1));
    send_word(make_cell(1'b1, 0, 0, 1'b0));
    send_word(make_cell(1'b1, 255, 255, 1'b1));
    send_word(make_cell(1'b1, 0, 255, 1'b0));
    send_word(make_cell(1'b1, 255, 0, 1'b0));
    send_word(make_cell(1'b0, 128, 128, 1'b1));
    repeat (3) send_word(make_cell(1'b1, 7, 9, 1'b0));
    send_word(make_cell(1'b1, 7, 9, 1'b1));
    send_word(make_cell(1'b1, 0, 0, 1'b0));
    send_word(make_cell(1'b1, 0, 255, 1'b0));
    send_word(make_cell(1'b1, 255, 0, 1'b0));
    send_word(make_cell(1'b0, 100, 200, 1'b0));
    send_word(make_cell(1'b1, 255, 255, 1'b1));
    send_word(make_cell(1'b1, 10, 20, 1'b0));
    send_word(make_cell(1'b1, 30, 40, 1'b0));
    send_word(make_cell(1'b1, 50, 60, 1'b1));
  endtask

  task automatic test_random_grids(input int budget, input int idle_pct, input int stall);
    int counted;
    counted = 0;
    set_pace(idle_pct, stall);
    while (counted < budget) send_random_grid(pick_grid_size(), counted);
  endtask

  // The receiver holds off while small grids keep arriving, so the input stalls.
  task automatic test_backpressure_fill();
    int counted;
    counted = 0;
    set_pace(0, 0);
    hold_tgl = ~hold_tgl;
    while (counted < 40) send_random_grid($urandom_range(5, 2), counted);
  endtask

  // The sender waits for every owed result before each new grid.
  task automatic test_drain_pause();
    int counted;
    counted = 0;
    set_pace(0, 30);
    repeat (4) begin
      send_random_grid($urandom_range(12, 3), counted);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while (owed_results.size() != 0) @(posedge clk_i);
    end
  endtask

  // One cell repeated past the ceiling, so its row and column counts saturate.
  task automatic test_count_saturation();
    set_pace(0, 0);
    repeat (SatRepeats) send_word(make_cell(1'b1, 7, 9, 1'b0));
    send_word(make_cell(1'b1, 200, 100, 1'b0));
    send_word(make_cell(1'b1, 3, 250, 1'b1));
  endtask

  // Receiver: random stalls, or a long hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result word taken with the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none owed: total_distance %0d occupied %0d",
                 $time, out_data_o.total_distance, out_data_o.occupied);
      end else begin
        if (out_data_o.total_distance !== owed_results[0].total_distance) begin
          errors++;
          $display("%0t: total_distance expected %0d got %0d", $time,
                   owed_results[0].total_distance, out_data_o.total_distance);
        end
        if (out_data_o.occupied !== owed_results[0].occupied) begin
          errors++;
          $display("%0t: occupied expected %0d got %0d", $time,
                   owed_results[0].occupied, out_data_o.occupied);
        end
        void'(owed_results.pop_front());
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no word moving.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("grid_l1_median_total_distance_tb: errors");
    $finish;
  end

  initial begin
    clear_grid();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_random_grids(300, 0, 0);
    test_random_grids(300, 75, 0);
    test_random_grids(300, 0, 75);
    test_random_grids(300, 26, 26);
    test_backpressure_fill();
    test_drain_pause();
    test_count_saturation();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // Drain the owed results, then watch for strays.
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("grid_l1_median_total_distance_tb: clean");
    else $display("grid_l1_median_total_distance_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/glmtd_pkg.sv
sv/glmtd_front.sv
sv/glmtd_queue.sv
sv/glmtd_axis.sv
sv/glmtd_back.sv
sv/grid_l1_median_total_distance.sv
test/grid_l1_median_total_distance_tb.sv
